@@ rtl/urt_pkg.sv @@
// Package for the unordered record table: transaction structs, request and status codes,
// controller states and the cell control struct.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package urt_pkg;

  localparam int KEY_W         = 31;
  localparam int PAYLOAD_W     = 16;
  localparam int SLOT_W        = 5;
  localparam int COUNT_OUT_W   = 6;
  localparam int DEFAULT_DEPTH = 32;
  localparam int SCAN_W        = 5;
  localparam int SCAN_GROUP    = 1 << SCAN_W;

  typedef enum logic [1:0] {
    REQ_APPEND       = 2'd0,
    REQ_LOOKUP       = 2'd1,
    REQ_REMOVE_SWAP  = 2'd2,
    REQ_REMOVE_SHIFT = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP,
    S_SCAN,
    S_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [KEY_W-1:0]     record_key;
    logic [PAYLOAD_W-1:0] record_payload;
    logic [SLOT_W-1:0]    slot_index;
  } urt_in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [SLOT_W-1:0]      found_index;
    logic [COUNT_OUT_W-1:0] entry_count;
  } urt_out_t;

  typedef struct packed {
    logic append;
    logic shift;
    logic swap;
    logic capture;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/urt_cell.sv @@
// One cell of the record chain: holds a key, a payload and a match flag.
// Depends on urt_pkg for the field widths and the cell control struct.
`default_nettype none

module urt_cell #(
  parameter int CNT_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  wire logic                           clk,
  input  wire urt_pkg::cell_ctl_t             ctl,
  input  wire logic [CNT_W-1:0]               count,
  input  wire logic [CNT_W-1:0]               slot,
  input  wire logic [urt_pkg::KEY_W-1:0]      new_key,
  input  wire logic [urt_pkg::PAYLOAD_W-1:0]  new_payload,
  input  wire logic [urt_pkg::KEY_W-1:0]      next_key,
  input  wire logic [urt_pkg::PAYLOAD_W-1:0]  next_payload,
  input  wire logic [urt_pkg::KEY_W-1:0]      last_key,
  input  wire logic [urt_pkg::PAYLOAD_W-1:0]  last_payload,
  output logic      [urt_pkg::KEY_W-1:0]      key,
  output logic      [urt_pkg::PAYLOAD_W-1:0]  payload,
  output logic                                match
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(CELL_IDX + 1);

  logic [urt_pkg::KEY_W-1:0]     key_r;
  logic [urt_pkg::KEY_W-1:0]     key_nxt;
  logic [urt_pkg::PAYLOAD_W-1:0] payload_r;
  logic [urt_pkg::PAYLOAD_W-1:0] payload_nxt;
  logic                          match_r;
  logic                          match_nxt;
  logic                          occupied;

  assign occupied = MY_IDX < count;

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    match_nxt   = match_r;
    if (ctl.append && (count == MY_IDX)) begin
      key_nxt     = new_key;
      payload_nxt = new_payload;
    end else if (ctl.swap && (slot == MY_IDX)) begin
      key_nxt     = last_key;
      payload_nxt = last_payload;
    end else if (ctl.shift && (MY_IDX >= slot) && (MY_NEXT < count)) begin
      key_nxt     = next_key;
      payload_nxt = next_payload;
    end
    if (ctl.capture) begin
      match_nxt = occupied && (key_r == new_key);
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
    match_r   <= match_nxt;
  end

  assign key     = key_r;
  assign payload = payload_r;
  assign match   = match_r;

endmodule

`default_nettype wire

@@ rtl/urt_scan.sv @@
// First-match finder: looks at one group of match flags and returns the lowest set position.
// Depends on urt_pkg for the group size.
`default_nettype none

module urt_scan #(
  parameter int NGRP  = 1,
  parameter int GRP_W = 1
) (
  input  wire logic [NGRP*urt_pkg::SCAN_GROUP-1:0] match_vec,
  input  wire logic [GRP_W-1:0]                    grp,
  output logic                                     hit,
  output logic      [GRP_W+urt_pkg::SCAN_W-1:0]    pos
);

  logic [urt_pkg::SCAN_GROUP-1:0] group_bits;
  logic [urt_pkg::SCAN_W-1:0]     low;

  assign group_bits = match_vec[grp*urt_pkg::SCAN_GROUP +: urt_pkg::SCAN_GROUP];
  assign hit        = |group_bits;
  assign pos        = {grp, low};

  always_comb begin
    logic [urt_pkg::SCAN_GROUP-1:0] v;
    logic [urt_pkg::SCAN_GROUP-1:0] mask;
    int                             half;
    v   = group_bits;
    low = '0;
    for (int k = urt_pkg::SCAN_W - 1; k >= 0; k--) begin
      half = 1 << k;
      mask = (urt_pkg::SCAN_GROUP'(1) << half) - urt_pkg::SCAN_GROUP'(1);
      if ((v & mask) == '0) begin
        low[k] = 1'b1;
        v      = v >> half;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/unordered_record_table.sv @@
// Top level of the unordered record table: controller, entry count and the chain of cells.
// Depends on urt_pkg, urt_cell and urt_scan.
`default_nettype none

// The table keeps up to TABLE_DEPTH records packed in positions 0 to count-1, one record per
// cell of a chain. One transaction is worked on at a time. An append, a shift-down removal or
// any rejected request goes from the execute state to the result state, which loads the output
// register. A swap-last removal passes a swap state between the two, as the last record is
// first latched and then written into the gap. A lookup searches at most ceil(TABLE_DEPTH/32)
// match groups: all cells compare in the same cycle, then the match flags are searched 32 at a
// time, stopping at the first group with a hit. The controller returns to idle as the result
// is loaded, so the next transaction can be accepted in the following cycle, even while that
// result still waits on the output. A result that is still waiting when the next one is ready
// holds the controller until it is taken. A full table, a lookup miss and a bad removal
// position are reported in the status field with found_index 0; found_index shows the low 5
// bits of the position for depths over 32, entry_count the low 6 bits of the count over 63.
module unordered_record_table #(
  parameter int TABLE_DEPTH = urt_pkg::DEFAULT_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire urt_pkg::urt_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output urt_pkg::urt_out_t      out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CMP_W = (CNT_W > urt_pkg::SLOT_W) ? CNT_W : urt_pkg::SLOT_W;
  localparam int NGRP  = (TABLE_DEPTH + urt_pkg::SCAN_GROUP - 1) / urt_pkg::SCAN_GROUP;
  localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  urt_pkg::ctrl_state_t state_r;
  urt_pkg::ctrl_state_t state_nxt;
  urt_pkg::urt_in_t     req_r;
  urt_pkg::urt_out_t    res_r;
  urt_pkg::urt_out_t    res_nxt;
  urt_pkg::urt_out_t    out_data_r;
  urt_pkg::cell_ctl_t   cell_ctl;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_load;
  logic                 last_load;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [CNT_W-1:0]     slot_c;
  logic [GRP_W-1:0]     grp_r;
  logic [GRP_W-1:0]     grp_nxt;
  logic [IDX_W-1:0]     last_idx;
  logic                 slot_ok;
  logic                 table_full;
  logic                 scan_hit;
  logic [GRP_W+urt_pkg::SCAN_W-1:0] scan_pos;

  logic [urt_pkg::KEY_W-1:0]     key_q [TABLE_DEPTH];
  logic [urt_pkg::PAYLOAD_W-1:0] pay_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]        match_q;
  logic [NGRP*urt_pkg::SCAN_GROUP-1:0] match_vec;
  logic [urt_pkg::KEY_W-1:0]     last_key_r;
  logic [urt_pkg::PAYLOAD_W-1:0] last_pay_r;

  assign in_ready   = (state_r == urt_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign slot_c     = CNT_W'(req_r.slot_index);
  assign slot_ok    = CMP_W'(req_r.slot_index) < CMP_W'(count_r);
  assign table_full = (count_r == CNT_W'(TABLE_DEPTH));
  assign last_idx   = IDX_W'(count_r - CNT_W'(1));

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int NXT = (i == TABLE_DEPTH - 1) ? i : i + 1;
    urt_cell #(
      .CNT_W   (CNT_W),
      .CELL_IDX(i)
    ) u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .count       (count_r),
      .slot        (slot_c),
      .new_key     (req_r.record_key),
      .new_payload (req_r.record_payload),
      .next_key    (key_q[NXT]),
      .next_payload(pay_q[NXT]),
      .last_key    (last_key_r),
      .last_payload(last_pay_r),
      .key         (key_q[i]),
      .payload     (pay_q[i]),
      .match       (match_q[i])
    );
  end

  always_comb begin
    match_vec                  = '0;
    match_vec[TABLE_DEPTH-1:0] = match_q;
  end

  urt_scan #(
    .NGRP (NGRP),
    .GRP_W(GRP_W)
  ) u_scan (
    .match_vec(match_vec),
    .grp      (grp_r),
    .hit      (scan_hit),
    .pos      (scan_pos)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      urt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = urt_pkg::S_EXEC;
        end
      end
      urt_pkg::S_EXEC: begin
        if (req_r.req_type == urt_pkg::REQ_LOOKUP) begin
          state_nxt = urt_pkg::S_SCAN;
        end else if ((req_r.req_type == urt_pkg::REQ_REMOVE_SWAP) && slot_ok) begin
          state_nxt = urt_pkg::S_SWAP;
        end else begin
          state_nxt = urt_pkg::S_RESULT;
        end
      end
      urt_pkg::S_SWAP: begin
        state_nxt = urt_pkg::S_RESULT;
      end
      urt_pkg::S_SCAN: begin
        if (scan_hit || (grp_r == GRP_W'(NGRP - 1))) begin
          state_nxt = urt_pkg::S_RESULT;
        end
      end
      urt_pkg::S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = urt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = urt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cell_ctl  = '0;
    count_nxt = count_r;
    res_nxt   = res_r;
    grp_nxt   = grp_r;
    last_load = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      urt_pkg::S_EXEC: begin
        res_nxt = '0;
        case (req_r.req_type)
          urt_pkg::REQ_APPEND: begin
            if (table_full) begin
              res_nxt.status = urt_pkg::ST_FULL;
            end else begin
              cell_ctl.append     = 1'b1;
              count_nxt           = count_r + CNT_W'(1);
              res_nxt.status      = urt_pkg::ST_OK;
              res_nxt.found_index = urt_pkg::SLOT_W'(count_r);
            end
          end
          urt_pkg::REQ_LOOKUP: begin
            cell_ctl.capture = 1'b1;
            grp_nxt          = '0;
            res_nxt.status   = urt_pkg::ST_NOT_FOUND;
          end
          urt_pkg::REQ_REMOVE_SWAP: begin
            if (slot_ok) begin
              last_load      = 1'b1;
              res_nxt.status = urt_pkg::ST_OK;
            end else begin
              res_nxt.status = urt_pkg::ST_BAD_POS;
            end
          end
          urt_pkg::REQ_REMOVE_SHIFT: begin
            if (slot_ok) begin
              cell_ctl.shift = 1'b1;
              count_nxt      = count_r - CNT_W'(1);
              res_nxt.status = urt_pkg::ST_OK;
            end else begin
              res_nxt.status = urt_pkg::ST_BAD_POS;
            end
          end
          default: begin
            res_nxt.status = urt_pkg::ST_BAD_POS;
          end
        endcase
      end
      urt_pkg::S_SWAP: begin
        cell_ctl.swap = 1'b1;
        count_nxt     = count_r - CNT_W'(1);
      end
      urt_pkg::S_SCAN: begin
        if (scan_hit) begin
          res_nxt.status      = urt_pkg::ST_OK;
          res_nxt.found_index = urt_pkg::SLOT_W'(scan_pos);
        end else begin
          grp_nxt = grp_r + GRP_W'(1);
        end
      end
      urt_pkg::S_RESULT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= urt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      grp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      grp_r       <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (last_load) begin
      last_key_r <= key_q[last_idx];
      last_pay_r <= pay_q[last_idx];
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r.status      <= res_r.status;
      out_data_r.found_index <= res_r.found_index;
      out_data_r.entry_count <= urt_pkg::COUNT_OUT_W'(count_r);
    end
  end

endmodule

`default_nettype wire

@@ rtl/urt_checker.sv @@
// Port-level checker for the unordered record table, bound to the top level.
// Depends on urt_pkg for the transaction structs and status codes.
`default_nettype none

module urt_checker #(
  parameter int TABLE_DEPTH = urt_pkg::DEFAULT_DEPTH
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire urt_pkg::urt_out_t out_data
);

  // A result that is not taken stays on the port unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("urt: result transaction changed while stalled");

  // Only one transaction is worked on at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("urt: input accepted while a transaction is in progress");

  // Any failed request reports position zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != urt_pkg::ST_OK) |-> out_data.found_index == '0)
    else $error("urt: nonzero position on a failed request");

  // A full table reports the whole depth as its count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == urt_pkg::ST_FULL)
      |-> out_data.entry_count == urt_pkg::COUNT_OUT_W'(TABLE_DEPTH))
    else $error("urt: table full reported with a short count");

endmodule

bind unordered_record_table urt_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_urt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
